// File: src/bhe_pkg.sv
// Package: payload types, constants and belt cipher helpers for the hash engine.
`timescale 1ns / 1ps
package bhe_pkg;

    localparam int CIPHER_ROUNDS_DEF = 8;
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef struct packed {
        logic [63:0] data_word;
        logic [3:0]  byte_count;
        logic        end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [63:0] digest_part;
        logic [1:0]  part_index;
        logic        last_part;
    } out_item_t;

    // classified word handed from front to back
    typedef struct packed {
        logic [63:0] word;
        logic [6:0]  add_bits;
        logic        has_slot;
        logic        last;
    } cmd_t;

    localparam logic [255:0] CHAIN_INIT = {
        32'h0dcefd02, 32'hc2722e25, 32'hacc7b61b, 32'h9dfa0485,
        32'he45d4a58, 32'h8e006d36, 32'h3bf5080a, 32'hc8ba94b1
    };

    localparam logic [7:0] SBOX [256] = '{
        8'hB1,8'h94,8'hBA,8'hC8,8'h0A,8'h08,8'hF5,8'h3B,8'h36,8'h6D,8'h00,8'h8E,8'h58,8'h4A,8'h5D,8'hE4,
        8'h85,8'h04,8'hFA,8'h9D,8'h1B,8'hB6,8'hC7,8'hAC,8'h25,8'h2E,8'h72,8'hC2,8'h02,8'hFD,8'hCE,8'h0D,
        8'h5B,8'hE3,8'hD6,8'h12,8'h17,8'hB9,8'h61,8'h81,8'hFE,8'h67,8'h86,8'hAD,8'h71,8'h6B,8'h89,8'h0B,
        8'h5C,8'hB0,8'hC0,8'hFF,8'h33,8'hC3,8'h56,8'hB8,8'h35,8'hC4,8'h05,8'hAE,8'hD8,8'hE0,8'h7F,8'h99,
        8'hE1,8'h2B,8'hDC,8'h1A,8'hE2,8'h82,8'h57,8'hEC,8'h70,8'h3F,8'hCC,8'hF0,8'h95,8'hEE,8'h8D,8'hF1,
        8'hC1,8'hAB,8'h76,8'h38,8'h9F,8'hE6,8'h78,8'hCA,8'hF7,8'hC6,8'hF8,8'h60,8'hD5,8'hBB,8'h9C,8'h4F,
        8'hF3,8'h3C,8'h65,8'h7B,8'h63,8'h7C,8'h30,8'h6A,8'hDD,8'h4E,8'hA7,8'h79,8'h9E,8'hB2,8'h3D,8'h31,
        8'h3E,8'h98,8'hB5,8'h6E,8'h27,8'hD3,8'hBC,8'hCF,8'h59,8'h1E,8'h18,8'h1F,8'h4C,8'h5A,8'hB7,8'h93,
        8'hE9,8'hDE,8'hE7,8'h2C,8'h8F,8'h0C,8'h0F,8'hA6,8'h2D,8'hDB,8'h49,8'hF4,8'h6F,8'h73,8'h96,8'h47,
        8'h06,8'h07,8'h53,8'h16,8'hED,8'h24,8'h7A,8'h37,8'h39,8'hCB,8'hA3,8'h83,8'h03,8'hA9,8'h8B,8'hF6,
        8'h92,8'hBD,8'h9B,8'h1C,8'hE5,8'hD1,8'h41,8'h01,8'h54,8'h45,8'hFB,8'hC9,8'h5E,8'h4D,8'h0E,8'hF2,
        8'h68,8'h20,8'h80,8'hAA,8'h22,8'h7D,8'h64,8'h2F,8'h26,8'h87,8'hF9,8'h34,8'h90,8'h40,8'h55,8'h11,
        8'hBE,8'h32,8'h97,8'h13,8'h43,8'hFC,8'h9A,8'h48,8'hA0,8'h2A,8'h88,8'h5F,8'h19,8'h4B,8'h09,8'hA1,
        8'h7E,8'hCD,8'hA4,8'hD0,8'h15,8'h44,8'hAF,8'h8C,8'hA5,8'h84,8'h50,8'hBF,8'h66,8'hD2,8'hE8,8'h8A,
        8'hA2,8'hD7,8'h46,8'h52,8'h42,8'hA8,8'hDF,8'hB3,8'h69,8'h74,8'hC5,8'h51,8'hEB,8'h23,8'h29,8'h21,
        8'hD4,8'hEF,8'hD9,8'hB4,8'h3A,8'h62,8'h28,8'h75,8'h91,8'h14,8'h10,8'hEA,8'h77,8'h6C,8'hDA,8'h1D
    };

    function automatic logic [31:0] gsub(input logic [31:0] a, input int r);
        logic [31:0] w;
        w = {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
        return (w << r) | (w >> (32 - r));
    endfunction

endpackage

// File: src/bhe_front.sv
// Front end: accepts items, masks invalid bytes and queues commands.
`timescale 1ns / 1ps
module bhe_front #(
    parameter int QUEUE_DEPTH = bhe_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bhe_pkg::in_item_t in_data,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output bhe_pkg::cmd_t     cmd
);
    import bhe_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    cmd_t          mem [QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   count_reg, count_next;
    logic [3:0]    n;
    logic [63:0]   mask;
    cmd_t          c;
    logic          push, pop;

    always_comb
    begin
        n = (in_data.byte_count > 4'd8) ? 4'd8 : in_data.byte_count;
        mask = (n == 4'd8) ? 64'hffff_ffff_ffff_ffff : ((64'd1 << {n, 3'b000}) - 64'd1);
        c.word = in_data.data_word & mask;
        c.add_bits = {n, 3'b000};
        c.has_slot = !in_data.end_of_message || (n != 4'd0);
        c.last = in_data.end_of_message;
    end

    assign in_ready  = (count_reg != (AW+1)'(QUEUE_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign push = in_valid && in_ready;
    assign pop  = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == AW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == AW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= c;
    end

    assign cmd = mem[rd_ptr_reg];
endmodule

// File: src/bhe_cipher.sv
// Belt block cipher, one round per cycle.
`timescale 1ns / 1ps
module bhe_cipher #(
    parameter int CIPHER_ROUNDS = bhe_pkg::CIPHER_ROUNDS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [127:0] blk_in,
    input  logic [255:0] key,
    output logic         done,
    output logic [127:0] blk_out
);
    import bhe_pkg::*;

    localparam int RW = $clog2(CIPHER_ROUNDS + 1);

    logic [31:0]   a_reg, b_reg, c_reg, d_reg;
    logic [255:0]  key_reg;
    logic [RW-1:0] rnd_reg;
    logic          busy_reg;
    logic [31:0]   a, b, c, d, e, t;
    logic [31:0]   k [7];
    logic [2:0]    base;

    always_comb
    begin
        base = 3'(7 * (int'(rnd_reg) - 1));
        for (int j = 0; j < 7; j++)
            k[j] = key_reg[32*(3'(base + 3'(j))) +: 32];
        a = a_reg; b = b_reg; c = c_reg; d = d_reg;
        b = b ^ gsub(a + k[0], 5);
        c = c ^ gsub(d + k[1], 21);
        a = a - gsub(b + k[2], 13);
        e = gsub(b + c + k[3], 21) ^ 32'(rnd_reg);
        b = b + e;
        c = c - e;
        d = d + gsub(c + k[4], 13);
        b = b ^ gsub(a + k[5], 21);
        c = c ^ gsub(d + k[6], 5);
        t = a; a = b; b = t;
        t = c; c = d; d = t;
        t = b; b = c; c = t;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            rnd_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                rnd_reg  <= RW'(1);
            end
            else if (busy_reg)
            begin
                rnd_reg <= rnd_reg + 1'b1;
                if (rnd_reg == RW'(CIPHER_ROUNDS))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            {d_reg, c_reg, b_reg, a_reg} <= blk_in;
            key_reg <= key;
        end
        else if (busy_reg)
        begin
            a_reg <= a; b_reg <= b; c_reg <= c; d_reg <= d;
        end
    end

    assign blk_out = {c_reg, a_reg, d_reg, b_reg};
endmodule

// File: src/bhe_back.sv
// Back end: block buffer, compression sequencer and digest output.
`timescale 1ns / 1ps
module bhe_back #(
    parameter int CIPHER_ROUNDS = bhe_pkg::CIPHER_ROUNDS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  bhe_pkg::cmd_t      cmd,
    output logic               out_valid,
    input  logic               out_ready,
    output bhe_pkg::out_item_t out_data
);
    import bhe_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_S1   = 3'd1;
    localparam logic [2:0] ST_S2A  = 3'd2;
    localparam logic [2:0] ST_S2B  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]   state_reg;
    logic [255:0] chain_reg, buf_reg, x_reg, y_reg;
    logic [127:0] sum_reg, len_reg, s_reg;
    logic [1:0]   fill_reg, part_reg;
    logic         fin_reg, pend_fin_reg;
    logic         c_start, c_done;
    logic [127:0] c_in, c_out, t;
    logic [255:0] c_key, buf_new, y_full;
    logic [2:0]   fill_sum;

    bhe_cipher #(.CIPHER_ROUNDS(CIPHER_ROUNDS)) u_cipher (
        .clk(clk), .rst_n(rst_n), .start(c_start), .blk_in(c_in),
        .key(c_key), .done(c_done), .blk_out(c_out)
    );

    assign t = chain_reg[127:0] ^ chain_reg[255:128];
    assign y_full = {c_out, y_reg[127:0]} ^ x_reg;
    // a pending final pass owns the idle cycle, so no command is taken then
    assign cmd_ready = (state_reg == ST_IDLE) && !pend_fin_reg;
    assign out_valid = (state_reg == ST_OUT);
    assign out_data.digest_part = y_reg[64*part_reg +: 64];
    assign out_data.part_index  = part_reg;
    assign out_data.last_part   = (part_reg == 2'd3);

    always_comb
    begin
        buf_new = buf_reg;
        buf_new[64*fill_reg +: 64] = cmd.word;
        fill_sum = {1'b0, fill_reg} + 3'd1;
    end

    always_comb
    begin
        c_in = t;
        c_key = x_reg;
        case (state_reg)
            ST_S1:
            begin
                c_in = t;
                c_key = x_reg;
            end
            ST_S2A:
            begin
                c_in = x_reg[127:0];
                c_key = {chain_reg[255:128], s_reg};
            end
            ST_S2B:
            begin
                c_in = x_reg[255:128];
                c_key = {chain_reg[127:0], ~s_reg};
            end
            default:
            begin
                c_in = t;
                c_key = x_reg;
            end
        endcase
    end

    // each phase starts the cipher on entry; go_reg pulses on the first cycle
    logic go_reg;
    assign c_start = go_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            chain_reg    <= CHAIN_INIT;
            sum_reg      <= '0;
            len_reg      <= '0;
            buf_reg      <= '0;
            fill_reg     <= '0;
            part_reg     <= '0;
            fin_reg      <= 1'b0;
            pend_fin_reg <= 1'b0;
            go_reg       <= 1'b0;
        end
        else
        begin
            go_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (pend_fin_reg)
                    begin
                        pend_fin_reg <= 1'b0;
                        fin_reg <= 1'b1;
                        x_reg <= {sum_reg, len_reg};
                        state_reg <= ST_S1;
                        go_reg <= 1'b1;
                    end
                    else if (cmd_valid)
                    begin
                        len_reg <= len_reg + 128'(cmd.add_bits);
                        if (cmd.has_slot && fill_sum[2])
                        begin
                            x_reg <= buf_new;
                            buf_reg <= '0;
                            fill_reg <= '0;
                            fin_reg <= 1'b0;
                            pend_fin_reg <= cmd.last;
                            state_reg <= ST_S1;
                            go_reg <= 1'b1;
                        end
                        else if (cmd.last)
                        begin
                            if (cmd.has_slot || fill_reg != 2'd0)
                            begin
                                x_reg <= cmd.has_slot ? buf_new : buf_reg;
                                buf_reg <= '0;
                                fill_reg <= '0;
                                fin_reg <= 1'b0;
                                pend_fin_reg <= 1'b1;
                            end
                            else
                            begin
                                fin_reg <= 1'b1;
                                x_reg <= {sum_reg,
                                          len_reg + 128'(cmd.add_bits)};
                            end
                            state_reg <= ST_S1;
                            go_reg <= 1'b1;
                        end
                        else
                        begin
                            buf_reg <= buf_new;
                            fill_reg <= fill_sum[1:0];
                        end
                    end
                end
                ST_S1:
                begin
                    if (c_done && !go_reg)
                    begin
                        s_reg <= c_out ^ t;
                        if (!fin_reg)
                            sum_reg <= sum_reg ^ c_out ^ t;
                        state_reg <= ST_S2A;
                        go_reg <= 1'b1;
                    end
                end
                ST_S2A:
                begin
                    if (c_done && !go_reg)
                    begin
                        y_reg[127:0] <= c_out;
                        state_reg <= ST_S2B;
                        go_reg <= 1'b1;
                    end
                end
                ST_S2B:
                begin
                    if (c_done && !go_reg)
                    begin
                        if (fin_reg)
                        begin
                            y_reg <= y_full;
                            part_reg <= '0;
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            chain_reg <= y_full;
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_OUT:
                begin
                    if (out_ready)
                    begin
                        part_reg <= part_reg + 1'b1;
                        if (part_reg == 2'd3)
                        begin
                            state_reg <= ST_IDLE;
                            chain_reg <= CHAIN_INIT;
                            sum_reg <= '0;
                            len_reg <= '0;
                            fin_reg <= 1'b0;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

// File: src/belt_hash_engine.sv
// Top level of the belt-hash engine.
//  channel | dir | handshake             | payload
//  in      | in  | in_valid / in_ready   | in_data  (data_word, byte_count, end_of_message)
//  out     | out | out_valid / out_ready | out_data (digest_part, part_index, last_part)
// A full 32-byte block costs three cipher passes (start, rounds, done; one shared
// round unit), and each item is taken only in the idle state; the final item adds
// one more compression when data is still buffered, plus the digest pass, then
// four output transfers.
// A small input queue keeps accepting, until it is full, while the back end works or stalls.
// Reset is asynchronous; state returns to the initial chain value.
`timescale 1ns / 1ps
module belt_hash_engine #(
    parameter int CIPHER_ROUNDS = bhe_pkg::CIPHER_ROUNDS_DEF,
    parameter int QUEUE_DEPTH   = bhe_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bhe_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output bhe_pkg::out_item_t out_data
);
    import bhe_pkg::*;

    logic cmd_valid, cmd_ready;
    cmd_t cmd;

    bhe_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_data(in_data), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
    );

    bhe_back #(.CIPHER_ROUNDS(CIPHER_ROUNDS)) u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
        .cmd(cmd), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );
endmodule

// File: src/bhe_checker.sv
// Port-level checks for the belt-hash engine, bound to the top level.
`timescale 1ns / 1ps
module bhe_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input bhe_pkg::out_item_t out_data
);
    import bhe_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output dropped while stalled");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.last_part == (out_data.part_index == 2'd3)))
        else $error("last_part mismatch");

    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last_part |=>
            out_valid && out_data.part_index == $past(out_data.part_index) + 2'd1)
        else $error("digest parts not consecutive");

    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_data.last_part |=> !out_valid)
        else $error("output after last part");
endmodule

bind belt_hash_engine bhe_checker u_bhe_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid),
    .out_ready(out_ready), .out_data(out_data)
);

// File: tb/tb_belt_hash_engine.sv
// Testbench for belt_hash_engine: random and directed messages checked against a built-in digest predictor.
`timescale 1ns / 1ps
module tb_belt_hash_engine;
    import bhe_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    belt_hash_engine DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    always
    begin
        clk = 1'b0; #2;
        clk = 1'b1; #2;
    end

    // predictor state
    logic [63:0] hv_chain [4];
    logic [63:0] hv_sum [2];
    logic [127:0] hv_bits;
    logic [63:0] hv_buf [4];
    int unsigned hv_fill;

    in_item_t  pending_items [$];
    out_item_t digest_parts [$];
    int unsigned mismatch_count = 0;
    int unsigned parts_seen = 0;
    int unsigned messages_sent = 0;
    bit stimulus_done = 0;
    bit hold_for_drain = 0;

    localparam logic [7:0] HTAB [256] = '{
        8'hB1,8'h94,8'hBA,8'hC8,8'h0A,8'h08,8'hF5,8'h3B,8'h36,8'h6D,8'h00,8'h8E,8'h58,8'h4A,8'h5D,8'hE4,
        8'h85,8'h04,8'hFA,8'h9D,8'h1B,8'hB6,8'hC7,8'hAC,8'h25,8'h2E,8'h72,8'hC2,8'h02,8'hFD,8'hCE,8'h0D,
        8'h5B,8'hE3,8'hD6,8'h12,8'h17,8'hB9,8'h61,8'h81,8'hFE,8'h67,8'h86,8'hAD,8'h71,8'h6B,8'h89,8'h0B,
        8'h5C,8'hB0,8'hC0,8'hFF,8'h33,8'hC3,8'h56,8'hB8,8'h35,8'hC4,8'h05,8'hAE,8'hD8,8'hE0,8'h7F,8'h99,
        8'hE1,8'h2B,8'hDC,8'h1A,8'hE2,8'h82,8'h57,8'hEC,8'h70,8'h3F,8'hCC,8'hF0,8'h95,8'hEE,8'h8D,8'hF1,
        8'hC1,8'hAB,8'h76,8'h38,8'h9F,8'hE6,8'h78,8'hCA,8'hF7,8'hC6,8'hF8,8'h60,8'hD5,8'hBB,8'h9C,8'h4F,
        8'hF3,8'h3C,8'h65,8'h7B,8'h63,8'h7C,8'h30,8'h6A,8'hDD,8'h4E,8'hA7,8'h79,8'h9E,8'hB2,8'h3D,8'h31,
        8'h3E,8'h98,8'hB5,8'h6E,8'h27,8'hD3,8'hBC,8'hCF,8'h59,8'h1E,8'h18,8'h1F,8'h4C,8'h5A,8'hB7,8'h93,
        8'hE9,8'hDE,8'hE7,8'h2C,8'h8F,8'h0C,8'h0F,8'hA6,8'h2D,8'hDB,8'h49,8'hF4,8'h6F,8'h73,8'h96,8'h47,
        8'h06,8'h07,8'h53,8'h16,8'hED,8'h24,8'h7A,8'h37,8'h39,8'hCB,8'hA3,8'h83,8'h03,8'hA9,8'h8B,8'hF6,
        8'h92,8'hBD,8'h9B,8'h1C,8'hE5,8'hD1,8'h41,8'h01,8'h54,8'h45,8'hFB,8'hC9,8'h5E,8'h4D,8'h0E,8'hF2,
        8'h68,8'h20,8'h80,8'hAA,8'h22,8'h7D,8'h64,8'h2F,8'h26,8'h87,8'hF9,8'h34,8'h90,8'h40,8'h55,8'h11,
        8'hBE,8'h32,8'h97,8'h13,8'h43,8'hFC,8'h9A,8'h48,8'hA0,8'h2A,8'h88,8'h5F,8'h19,8'h4B,8'h09,8'hA1,
        8'h7E,8'hCD,8'hA4,8'hD0,8'h15,8'h44,8'hAF,8'h8C,8'hA5,8'h84,8'h50,8'hBF,8'h66,8'hD2,8'hE8,8'h8A,
        8'hA2,8'hD7,8'h46,8'h52,8'h42,8'hA8,8'hDF,8'hB3,8'h69,8'h74,8'hC5,8'h51,8'hEB,8'h23,8'h29,8'h21,
        8'hD4,8'hEF,8'hD9,8'hB4,8'h3A,8'h62,8'h28,8'h75,8'h91,8'h14,8'h10,8'hEA,8'h77,8'h6C,8'hDA,8'h1D
    };

    function automatic logic [31:0] sub_rot(input logic [31:0] a, input int r);
        logic [31:0] w;
        w = {HTAB[a[31:24]], HTAB[a[23:16]], HTAB[a[15:8]], HTAB[a[7:0]]};
        return (w << r) | (w >> (32 - r));
    endfunction

    typedef logic [31:0] w4_t [4];
    typedef logic [31:0] w8_t [8];

    function automatic w4_t belt_encrypt(input w4_t blk, input w8_t key);
        logic [31:0] a, b, c, d, e, t;
        int base;
        w4_t res;
        a = blk[0]; b = blk[1]; c = blk[2]; d = blk[3];
        for (int i = 1; i <= 8; i++)
        begin
            base = 7 * (i - 1);
            b = b ^ sub_rot(a + key[(base + 0) % 8], 5);
            c = c ^ sub_rot(d + key[(base + 1) % 8], 21);
            a = a - sub_rot(b + key[(base + 2) % 8], 13);
            e = sub_rot(b + c + key[(base + 3) % 8], 21) ^ 32'(i);
            b = b + e;
            c = c - e;
            d = d + sub_rot(c + key[(base + 4) % 8], 13);
            b = b ^ sub_rot(a + key[(base + 5) % 8], 21);
            c = c ^ sub_rot(d + key[(base + 6) % 8], 5);
            t = a; a = b; b = t;
            t = c; c = d; d = t;
            t = b; b = c; c = t;
        end
        res[0] = b; res[1] = d; res[2] = a; res[3] = c;
        return res;
    endfunction

    function automatic w4_t mix_sum(input w8_t x, input w8_t h);
        w4_t t, o;
        for (int j = 0; j < 4; j++) t[j] = h[j] ^ h[j + 4];
        o = belt_encrypt(t, x);
        for (int j = 0; j < 4; j++) o[j] = o[j] ^ t[j];
        return o;
    endfunction

    function automatic w8_t mix_chain(input w8_t x, input w8_t h);
        w4_t s, lo, hi, xl, xh;
        w8_t k1, k2, o;
        s = mix_sum(x, h);
        for (int j = 0; j < 4; j++)
        begin
            k1[j] = s[j]; k1[j + 4] = h[j + 4];
            k2[j] = ~s[j]; k2[j + 4] = h[j];
            xl[j] = x[j]; xh[j] = x[j + 4];
        end
        lo = belt_encrypt(xl, k1);
        hi = belt_encrypt(xh, k2);
        for (int j = 0; j < 4; j++)
        begin
            o[j] = lo[j] ^ x[j];
            o[j + 4] = hi[j] ^ x[j + 4];
        end
        return o;
    endfunction

    task automatic hash_clear();
        hv_chain[0] = 64'h3bf5080ac8ba94b1;
        hv_chain[1] = 64'he45d4a588e006d36;
        hv_chain[2] = 64'hacc7b61b9dfa0485;
        hv_chain[3] = 64'h0dcefd02c2722e25;
        hv_sum[0] = '0; hv_sum[1] = '0;
        hv_bits = '0;
        for (int j = 0; j < 4; j++) hv_buf[j] = '0;
        hv_fill = 0;
    endtask

    task automatic hash_compress();
        w8_t x, h, hn;
        w4_t s;
        for (int j = 0; j < 4; j++)
        begin
            x[2*j] = hv_buf[j][31:0]; x[2*j+1] = hv_buf[j][63:32];
            h[2*j] = hv_chain[j][31:0]; h[2*j+1] = hv_chain[j][63:32];
        end
        s = mix_sum(x, h);
        hn = mix_chain(x, h);
        hv_sum[0] = hv_sum[0] ^ {s[1], s[0]};
        hv_sum[1] = hv_sum[1] ^ {s[3], s[2]};
        for (int j = 0; j < 4; j++)
        begin
            hv_chain[j] = {hn[2*j+1], hn[2*j]};
            hv_buf[j] = '0;
        end
        hv_fill = 0;
    endtask

    task automatic predict_digest(input in_item_t it);
        logic [63:0] w;
        int unsigned n;
        w8_t x, h, y;
        out_item_t p;
        n = (it.byte_count > 8) ? 8 : it.byte_count;
        w = it.data_word;
        if (n < 8) w = w & ((64'd1 << (8 * n)) - 64'd1);
        hv_bits = hv_bits + 128'(n * 8);
        if (!it.end_of_message || n > 0)
        begin
            hv_buf[hv_fill] = w;
            hv_fill++;
            if (hv_fill == 4) hash_compress();
        end
        if (it.end_of_message)
        begin
            if (hv_fill > 0) hash_compress();
            x[0] = hv_bits[31:0]; x[1] = hv_bits[63:32];
            x[2] = hv_bits[95:64]; x[3] = hv_bits[127:96];
            x[4] = hv_sum[0][31:0]; x[5] = hv_sum[0][63:32];
            x[6] = hv_sum[1][31:0]; x[7] = hv_sum[1][63:32];
            for (int j = 0; j < 4; j++)
            begin
                h[2*j] = hv_chain[j][31:0]; h[2*j+1] = hv_chain[j][63:32];
            end
            y = mix_chain(x, h);
            for (int k = 0; k < 4; k++)
            begin
                p.digest_part = {y[2*k+1], y[2*k]};
                p.part_index = 2'(k);
                p.last_part = (k == 3);
                digest_parts.push_back(p);
            end
            hash_clear();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    function automatic in_item_t make_item(input logic [63:0] w, input int n, input bit eom);
        in_item_t it;
        it.data_word = w;
        it.byte_count = 4'(n);
        it.end_of_message = eom;
        return it;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // driver
    int unsigned gap_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_digest(in_data);
                gap_left = $urandom_range(0, 6);
                if ($urandom_range(0, 3) == 0) gap_left = 0;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() > 0 &&
                         !(hold_for_drain && digest_parts.size() > 0))
                begin
                    in_valid <= 1'b1;
                    in_data <= pending_items.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor and receiver stalls
    int unsigned stall_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                parts_seen++;
                if (digest_parts.size() == 0)
                    report_mismatch("unexpected part", out_data.digest_part, 64'd0);
                else
                begin
                    out_item_t e;
                    e = digest_parts.pop_front();
                    if (out_data.digest_part !== e.digest_part)
                        report_mismatch("digest_part", out_data.digest_part, e.digest_part);
                    if (out_data.part_index !== e.part_index)
                        report_mismatch("part_index", 64'(out_data.part_index),
                                        64'(e.part_index));
                    if (out_data.last_part !== e.last_part)
                        report_mismatch("last_part", 64'(out_data.last_part),
                                        64'(e.last_part));
                end
                stall_left = $urandom_range(0, 6);
                if ($urandom_range(0, 3) == 0) stall_left = 0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic queue_message(input int words, input int tail_bytes);
        for (int i = 0; i < words; i++)
            pending_items.push_back(make_item(rand64(), 8, 1'b0));
        pending_items.push_back(make_item(rand64(), tail_bytes, 1'b1));
        messages_sent++;
    endtask

    initial
    begin
        int total;
        hash_clear();
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty message, extremes, short non-last items, oversize counts
        pending_items.push_back(make_item(64'd0, 0, 1'b1));
        pending_items.push_back(make_item('1, 8, 1'b1));
        pending_items.push_back(make_item('0, 8, 1'b0));
        pending_items.push_back(make_item('1, 15, 1'b1));
        pending_items.push_back(make_item('1, 3, 1'b0));
        pending_items.push_back(make_item(64'h0123456789abcdef, 9, 1'b0));
        pending_items.push_back(make_item('1, 1, 1'b1));
        for (int i = 0; i < 4; i++)
            pending_items.push_back(make_item(rand64(), 8, 1'b0));
        pending_items.push_back(make_item(rand64(), 0, 1'b1));   // exact block
        for (int i = 0; i < 3; i++)
            pending_items.push_back(make_item('1, 8, 1'b0));
        pending_items.push_back(make_item('1, 8, 1'b1));         // block ends on last
        pending_items.push_back(make_item(rand64(), 5, 1'b0));
        pending_items.push_back(make_item(rand64(), 7, 1'b1));
        messages_sent += 7;
        total = pending_items.size();

        // hold the sender once until all digests are out
        wait (pending_items.size() == 0);
        hold_for_drain = 1;
        queue_message(2, 4);
        wait (pending_items.size() == 0 && digest_parts.size() == 0);
        hold_for_drain = 0;

        total = 0;
        while (total < 260)
        begin
            int words;
            if ($urandom_range(0, 9) == 0)
            begin
                // noise: odd counts anywhere
                words = $urandom_range(0, 5);
                for (int i = 0; i < words; i++)
                    pending_items.push_back(make_item(rand64(), $urandom_range(0, 15), 1'b0));
                pending_items.push_back(make_item(rand64(), $urandom_range(0, 15), 1'b1));
                messages_sent++;
            end
            else
            begin
                words = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 16)
                                                    : $urandom_range(0, 6);
                queue_message(words, $urandom_range(0, 8));
            end
            total += words + 1;
            wait (pending_items.size() < 8);
        end
        wait (pending_items.size() == 0 && !in_valid);
        stimulus_done = 1;
        wait (digest_parts.size() == 0);
        repeat (100) @(posedge clk);
        $display("ran %0d messages, %0d digest parts checked, with random gaps and stalls",
                 messages_sent, parts_seen);
        if (mismatch_count == 0 && digest_parts.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("timeout waiting for digest output");
        $display("end of test: mismatches");
        $finish;
    end
endmodule
